### rtl/pda_pkg.sv
// Shared constants, types and helpers for the pixel dedup accumulator.
package pda_pkg;

    localparam int INDEX_BITS = 16;
    localparam int BUF_DEPTH  = 64;
    localparam int SLOT_BITS  = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int CNT_BITS   = $clog2(BUF_DEPTH + 1);
    localparam int LIMIT_BITS = 7;
    localparam int DATA_BITS  = 32;
    localparam int ENT_BITS   = SLOT_BITS + 1;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(64);
    localparam logic [LIMIT_BITS-1:0] LIMIT_MAX   = LIMIT_BITS'(BUF_DEPTH);
    localparam logic CMD_ACCUM = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;
    localparam logic [DATA_BITS-1:0] SAT_MAX = '1;

    typedef struct packed {
        logic [DATA_BITS-1:0] blue;
        logic [DATA_BITS-1:0] green;
        logic [DATA_BITS-1:0] red;
        logic [DATA_BITS-1:0] offset;
    } t_pix;

    typedef struct packed {
        logic is_flush;
        t_pix pix;
    } t_item;

    typedef struct packed {
        logic                clearing;
        logic [CNT_BITS-1:0] used;
    } t_status;

    function automatic logic [DATA_BITS-1:0] sat_add(input logic [DATA_BITS-1:0] a,
                                                    input logic [DATA_BITS-1:0] b);
        logic [DATA_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DATA_BITS] ? SAT_MAX : s[DATA_BITS-1:0];
    endfunction

endpackage

### rtl/pda_front.sv
// Input queue that accepts and classifies items ahead of the engine.
module pda_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_hold,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_cmd,
    input  pda_pkg::t_pix     i_pix,
    output logic              o_valid,
    output pda_pkg::t_item    o_item,
    input  logic              i_pop
);
    import pda_pkg::*;

    t_item       r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        push;

    assign o_ready = (r_cnt != 2'd2) && !i_hold;
    assign push    = i_valid && o_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp].is_flush <= (i_cmd == CMD_FLUSH);
            r_q[r_wp].pix      <= i_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push)  r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

endmodule

### rtl/pda_engine.sv
// Back end: index and slot memories, accumulation, flush walk and output register.
module pda_engine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [pda_pkg::LIMIT_BITS-1:0] i_limit,
    input  logic                           i_valid,
    input  pda_pkg::t_item                 i_item,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_ready,
    output pda_pkg::t_pix                  o_pix,
    output logic                           o_last,
    output pda_pkg::t_status               o_status
);
    import pda_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_LOOK  = 3'd2;
    localparam logic [2:0] ST_ACC   = 3'd3;
    localparam logic [2:0] ST_CHECK = 3'd4;
    localparam logic [2:0] ST_FREAD = 3'd5;
    localparam logic [2:0] ST_FEMIT = 3'd6;

    logic [2:0]            r_state, n_state;
    t_item                 r_item, n_item;
    logic [CNT_BITS-1:0]   r_count, n_count;
    logic [CNT_BITS-1:0]   r_fidx, n_fidx;
    logic [INDEX_BITS-1:0] r_clr, n_clr;
    logic                  r_mv, n_mv;
    t_pix                  r_mpix, n_mpix;
    logic                  r_mlast, n_mlast;

    logic [ENT_BITS-1:0]   m_index [2**INDEX_BITS];
    logic [ENT_BITS-1:0]   r_ent;
    t_pix                  m_slot [BUF_DEPTH];
    t_pix                  r_sdata;

    logic                  idx_we;
    logic [INDEX_BITS-1:0] idx_wa, idx_ra;
    logic [ENT_BITS-1:0]   idx_wd;
    logic                  slot_we;
    logic [SLOT_BITS-1:0]  slot_wa, slot_ra;
    t_pix                  slot_wd;

    logic [LIMIT_BITS-1:0] eff_limit;
    logic                  at_limit, out_free, hit;

    always_comb begin
        if (i_limit == '0)          eff_limit = LIMIT_BITS'(1);
        else if (i_limit > LIMIT_MAX) eff_limit = LIMIT_MAX;
        else                         eff_limit = i_limit;
    end

    assign at_limit = LIMIT_BITS'(r_count) >= eff_limit;
    assign out_free = !r_mv || i_ready;
    assign hit      = (r_sdata.offset == r_item.pix.offset);

    always_ff @(posedge i_clk) begin
        if (idx_we) m_index[idx_wa] <= idx_wd;
        r_ent <= m_index[idx_ra];
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) m_slot[slot_wa] <= slot_wd;
        r_sdata <= m_slot[slot_ra];
    end

    always_comb begin
        n_state = r_state;
        n_item  = r_item;
        n_count = r_count;
        n_fidx  = r_fidx;
        n_clr   = r_clr;
        n_mpix  = r_mpix;
        n_mlast = r_mlast;
        n_mv    = r_mv && !i_ready;
        o_pop   = 1'b0;
        idx_we  = 1'b0;
        idx_wa  = r_clr;
        idx_wd  = '0;
        idx_ra  = r_item.pix.offset[INDEX_BITS-1:0];
        slot_we = 1'b0;
        slot_wa = r_ent[SLOT_BITS-1:0];
        slot_wd = r_item.pix;
        slot_ra = r_ent[SLOT_BITS-1:0];

        unique case (r_state)
            ST_CLEAR: begin
                idx_we = 1'b1;
                n_clr  = r_clr + 1'b1;
                if (r_clr == '1) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                idx_ra = i_item.pix.offset[INDEX_BITS-1:0];
                if (i_valid) begin
                    o_pop   = 1'b1;
                    n_item  = i_item;
                    n_state = i_item.is_flush ? ST_CHECK : ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (!r_ent[SLOT_BITS]) begin
                    // Empty entry: take the next free slot.
                    if (r_count < CNT_BITS'(BUF_DEPTH)) begin
                        slot_we = 1'b1;
                        slot_wa = r_count[SLOT_BITS-1:0];
                        idx_we  = 1'b1;
                        idx_wa  = r_item.pix.offset[INDEX_BITS-1:0];
                        idx_wd  = {1'b1, r_count[SLOT_BITS-1:0]};
                        n_count = r_count + 1'b1;
                    end
                    n_state = ST_CHECK;
                end else begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                if (hit) begin
                    slot_we       = 1'b1;
                    slot_wd.offset = r_sdata.offset;
                    slot_wd.red   = sat_add(r_sdata.red,   r_item.pix.red);
                    slot_wd.green = sat_add(r_sdata.green, r_item.pix.green);
                    slot_wd.blue  = sat_add(r_sdata.blue,  r_item.pix.blue);
                    n_state       = ST_CHECK;
                end else if (out_free) begin
                    // Collision: pass the pixel through; a following flush owns last.
                    n_mv    = 1'b1;
                    n_mpix  = r_item.pix;
                    n_mlast = !at_limit;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_fidx = '0;
                if (r_item.is_flush ? (r_count != '0) : at_limit) n_state = ST_FREAD;
                else                                             n_state = ST_IDLE;
            end
            ST_FREAD: begin
                slot_ra = r_fidx[SLOT_BITS-1:0];
                n_state = ST_FEMIT;
            end
            ST_FEMIT: begin
                slot_ra = r_fidx[SLOT_BITS-1:0];
                if (out_free) begin
                    n_mv    = 1'b1;
                    n_mpix  = r_sdata;
                    n_mlast = (r_fidx + 1'b1 == r_count);
                    idx_we  = 1'b1;
                    idx_wa  = r_sdata.offset[INDEX_BITS-1:0];
                    idx_wd  = '0;
                    if (r_fidx + 1'b1 == r_count) begin
                        n_count = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_fidx  = r_fidx + 1'b1;
                        n_state = ST_FREAD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_fidx  <= n_fidx;
        r_mpix  <= n_mpix;
        r_mlast <= n_mlast;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_count <= '0;
            r_clr   <= '0;
            r_mv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_clr   <= n_clr;
            r_mv    <= n_mv;
        end
    end

    assign o_valid           = r_mv;
    assign o_pix             = r_mpix;
    assign o_last            = r_mlast;
    assign o_status.clearing = (r_state == ST_CLEAR);
    assign o_status.used     = r_count;

endmodule

### rtl/pixel_dedup_accumulator.sv
// Top level of the pixel dedup accumulator: ports, limit register and checks.
//
// Pixels enter on the s_axis channel, one transfer per item: tdata carries the
// offset and the red, green and blue values, tuser carries the command (0 adds
// the pixel, 1 flushes the buffer). Results leave on the m_axis channel with
// tlast set on the final result caused by an input item. The buffer_limit
// register is written through the cfg channel, which is always ready.
// A two-entry input queue decouples the port from the engine, which takes
// queued items in order and handles one item at a time. A pixel that opens
// a new slot passes through index read, slot write and limit check; a pixel
// whose index entry is in use passes through index read, slot read, merge or
// pass-through and limit check. A flush walks the used slots, each read from
// the registered slot memory before it moves into the output register.
// After reset the engine clears all 2**INDEX_BITS (65536) index entries, one
// entry per cycle; s_axis_tready stays low meanwhile.
// When the receiver stalls, the engine holds its result in the output
// register and stops once it has another result to emit; the input queue
// then fills and drops tready.
module pixel_dedup_accumulator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [127:0]                    s_axis_tdata,  // offset, red, green, blue
    input  logic                            s_axis_tuser,  // cmd
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [127:0]                    m_axis_tdata,  // offset, red, green, blue
    output logic                            m_axis_tlast,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pda_pkg::LIMIT_BITS-1:0]  i_cfg_data
);
    import pda_pkg::*;

    logic [LIMIT_BITS-1:0] r_limit;
    t_item                 q_item;
    logic                  q_valid, q_pop;
    t_pix                  in_pix, out_pix;
    t_status               status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    // The packed pixel struct puts the offset in the low bits, as on the bus.
    assign in_pix       = s_axis_tdata;
    assign m_axis_tdata = out_pix;

    pda_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hold  (status.clearing),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_cmd   (s_axis_tuser),
        .i_pix   (in_pix),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    pda_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_limit  (r_limit),
        .i_valid  (q_valid),
        .i_item   (q_item),
        .o_pop    (q_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_pix    (out_pix),
        .o_last   (m_axis_tlast),
        .o_status (status)
    );

`ifndef ASSERT_OFF
    a_no_input_while_clearing: assert property (@(posedge i_clk)
        status.clearing |-> !s_axis_tready)
        else $error("input accepted during index clearing");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.used <= CNT_BITS'(BUF_DEPTH))
        else $error("used slot count beyond buffer depth");

    a_clear_leaves_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(status.clearing) |-> (status.used == '0) && !m_axis_tvalid)
        else $error("buffer not empty after index clearing");
`endif

endmodule

### bench/tb_pixel_dedup_accumulator.sv
// Self-checking testbench for the pixel dedup accumulator.
module tb_pixel_dedup_accumulator;
    timeunit 1ns;
    timeprecision 1ps;
    import pda_pkg::*;

    typedef struct packed {
        logic [31:0] offset;
        logic [31:0] red;
        logic [31:0] green;
        logic [31:0] blue;
        logic        last;
    } t_emit;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic         m_axis_tlast;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [LIMIT_BITS-1:0] i_cfg_data = '0;

    // Predictor state: index entries hold a valid bit and a slot number.
    logic [SLOT_BITS:0]   idx_mem [0:(1<<INDEX_BITS)-1];
    logic [31:0]          sl_off [0:BUF_DEPTH-1];
    logic [31:0]          sl_r [0:BUF_DEPTH-1];
    logic [31:0]          sl_g [0:BUF_DEPTH-1];
    logic [31:0]          sl_b [0:BUF_DEPTH-1];
    int unsigned          fill_count;
    int unsigned          limit_reg;
    t_emit                pending_pixels[$];
    int                   errors = 0;
    longint               cycles = 0;
    bit                   quiet_stretch = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    pixel_dedup_accumulator u_top (.*);

    task automatic report(input string what);
        errors++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    function automatic logic [31:0] clamp_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Emit every used slot in order; the final one carries last. A pass-through
    // result of the same item loses its last flag when slots follow it.
    function automatic void drain_slots(input bit after_pass);
        int unsigned n;
        t_emit e;
        n = fill_count;
        if (n > 0 && after_pass && pending_pixels.size() > 0)
            pending_pixels[$].last = 1'b0;
        for (int unsigned i = 0; i < n; i++) begin
            e = '{sl_off[i], sl_r[i], sl_g[i], sl_b[i], (i + 1 == n)};
            pending_pixels.push_back(e);
            idx_mem[sl_off[i][INDEX_BITS-1:0]] = '0;
        end
        fill_count = 0;
    endfunction

    function automatic void predict_pixel(input logic cmd, input logic [31:0] off,
                                          input logic [31:0] r, input logic [31:0] g,
                                          input logic [31:0] b);
        logic [SLOT_BITS:0] ent;
        int unsigned s, eff;
        bit collided;
        collided = 0;
        if (cmd == CMD_FLUSH) begin
            drain_slots(1'b0);
            return;
        end
        ent = idx_mem[off[INDEX_BITS-1:0]];
        if (!ent[SLOT_BITS]) begin
            if (fill_count < BUF_DEPTH) begin
                s = fill_count;
                sl_off[s] = off; sl_r[s] = r; sl_g[s] = g; sl_b[s] = b;
                idx_mem[off[INDEX_BITS-1:0]] = {1'b1, SLOT_BITS'(s)};
                fill_count++;
            end
        end else begin
            s = 32'(ent[SLOT_BITS-1:0]);
            if (sl_off[s] == off) begin
                sl_r[s] = clamp_add(sl_r[s], r);
                sl_g[s] = clamp_add(sl_g[s], g);
                sl_b[s] = clamp_add(sl_b[s], b);
            end else begin
                pending_pixels.push_back('{off, r, g, b, 1'b1});
                collided = 1;
            end
        end
        eff = (limit_reg == 0) ? 1 : (limit_reg > BUF_DEPTH) ? BUF_DEPTH : limit_reg;
        if (fill_count >= eff)
            drain_slots(collided);
    endfunction

    // Take a break with a chance of 27 in 100 unless in a quiet stretch.
    function automatic bit take_break();
        return !quiet_stretch && ($urandom_range(99) < 27);
    endfunction

    task automatic send_pixel(input logic cmd, input logic [31:0] off,
                              input logic [31:0] r, input logic [31:0] g,
                              input logic [31:0] b);
        while (take_break()) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {b, g, r, off};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_pixel(cmd, off, r, g, b);
    endtask

    task automatic drain_wait();
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_limit(input int unsigned v);
        drain_wait();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= LIMIT_BITS'(v);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        limit_reg = v & 7'h7F;
    endtask

    // Result checker; the transfer is sampled at the edge.
    always @(posedge i_clk) begin
        t_emit want;
        if (i_rst_n) begin
            m_axis_tready <= !take_break();
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_pixels.size() == 0) begin
                    report("unexpected result transfer");
                end else begin
                    want = pending_pixels.pop_front();
                    if (m_axis_tdata[31:0] !== want.offset)
                        report($sformatf("offset %h want %h", m_axis_tdata[31:0], want.offset));
                    if (m_axis_tdata[63:32] !== want.red)
                        report($sformatf("red %h want %h", m_axis_tdata[63:32], want.red));
                    if (m_axis_tdata[95:64] !== want.green)
                        report($sformatf("green %h want %h", m_axis_tdata[95:64], want.green));
                    if (m_axis_tdata[127:96] !== want.blue)
                        report($sformatf("blue %h want %h", m_axis_tdata[127:96], want.blue));
                    if (m_axis_tlast !== want.last)
                        report($sformatf("last %b want %b", m_axis_tlast, want.last));
                end
            end
        end
    end

    // Watchdog covers the index clear pass after reset and the whole run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 400000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Merging, collisions, saturation, flush of an empty buffer.
    task automatic test_directed();
        send_pixel(CMD_FLUSH, 32'hFFFF_FFFF, '1, '1, '1);
        send_pixel(CMD_ACCUM, 32'h0000_0005, 32'hFFFF_FFF0, 32'd1, 32'd0);
        send_pixel(CMD_ACCUM, 32'h0000_0005, 32'h0000_0100, 32'd2, 32'hFFFF_FFFF);
        send_pixel(CMD_ACCUM, 32'h0001_0005, 32'h1234_5678, 32'd3, 32'd4);
        send_pixel(CMD_ACCUM, 32'hFFFF_FFFF, '1, '1, '1);
        send_pixel(CMD_ACCUM, 32'hFFFF_FFFF, '1, '1, '1);
        send_pixel(CMD_ACCUM, 32'h0000_0000, '0, '0, '0);
        send_pixel(CMD_FLUSH, '0, '0, '0, '0);
        send_pixel(CMD_FLUSH, '0, '0, '0, '0);
    endtask

    // Limits at the edges, including out-of-range values and a lowered limit.
    task automatic test_limits();
        set_limit(1);
        send_pixel(CMD_ACCUM, 32'h10, 1, 2, 3);
        set_limit(3);
        send_pixel(CMD_ACCUM, 32'h20, 1, 1, 1);
        send_pixel(CMD_ACCUM, 32'h21, 1, 1, 1);
        // A collision on the step just before the one that fills the buffer.
        send_pixel(CMD_ACCUM, 32'h1_0020, 7, 7, 7);
        send_pixel(CMD_ACCUM, 32'h22, 1, 1, 1);
        send_pixel(CMD_ACCUM, 32'h30, 1, 1, 1);
        send_pixel(CMD_ACCUM, 32'h31, 1, 1, 1);
        set_limit(1);
        send_pixel(CMD_ACCUM, 32'h31, 5, 5, 5);
        set_limit(0);
        send_pixel(CMD_ACCUM, 32'h40, 1, 1, 1);
        set_limit(127);
        for (int i = 0; i < 64; i++)
            send_pixel(CMD_ACCUM, 32'h100 + i, $urandom, $urandom, $urandom);
    endtask

    // Random pixels on a small offset pool so merges and collisions are common.
    task automatic test_random(input int n, input int unsigned lim);
        logic [31:0] off;
        set_limit(lim);
        for (int i = 0; i < n; i++) begin
            quiet_stretch = (i >= n / 3) && (i < n / 2);
            off = {14'($urandom_range(3)), 12'h0, 6'($urandom_range(15))};
            if ($urandom_range(9) == 0) off = $urandom;
            case ($urandom_range(2))
                0: send_pixel(CMD_ACCUM, off, $urandom, $urandom, $urandom);
                1: send_pixel(CMD_ACCUM, off, $urandom_range(255),
                              32'hFFFF_FF00 | $urandom_range(255),
                              $urandom_range(65535));
                default: send_pixel($urandom_range(19) == 0, off, $urandom, $urandom_range(9),
                                    32'h8000_0000 | $urandom);
            endcase
        end
        quiet_stretch = 0;
        send_pixel(CMD_FLUSH, $urandom, $urandom, $urandom, $urandom);
    endtask

    initial begin
        for (int i = 0; i < (1 << INDEX_BITS); i++) idx_mem[i] = '0;
        fill_count = 0;
        limit_reg = LIMIT_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_limits();
        test_random(90, 5);
        test_random(90, 64);
        test_random(90, 17);
        test_random(40, 1);
        drain_wait();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
